[rtl/bc7m6_pkg.sv]
// Package for the BC7 mode 6 block decoder: shared types, constants and the
// interpolation weight table. Used by every module in rtl/.
package bc7m6_pkg;

   localparam int NUM_TEXELS = 16;
   localparam int IDX_W      = 4;
   localparam int CHAN_W     = 8;
   localparam int WEIGHT_W   = 7;
   localparam int QDEPTH     = 2;

   // Mode 6 marker in the low seven bits: six zeros then a one
   localparam logic [6:0] MODE6_CODE = 7'b100_0000;

   localparam logic [IDX_W-1:0] LAST_TEXEL = 4'(NUM_TEXELS - 1);

   // Magenta fill for blocks of any other mode
   localparam logic [CHAN_W-1:0] FILL_RED   = 8'd255;
   localparam logic [CHAN_W-1:0] FILL_GREEN = 8'd0;
   localparam logic [CHAN_W-1:0] FILL_BLUE  = 8'd255;
   localparam logic [CHAN_W-1:0] FILL_ALPHA = 8'd255;

   localparam logic [WEIGHT_W-1:0] ROUND_BIAS = 7'd32;

   // Decoded block as it travels from front to back
   typedef struct packed {
      logic                                  mode_ok;
      logic [3:0][CHAN_W-1:0]                ep0;  // r,g,b,a at [0..3]
      logic [3:0][CHAN_W-1:0]                ep1;
      logic [NUM_TEXELS-1:0][IDX_W-1:0]      idx;
   } desc_type;

   // Queue status seen by the back end and by the top level's full output
   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   // Fixed 4-bit index weight table
   function automatic logic [WEIGHT_W-1:0] weight(input logic [IDX_W-1:0] idx);
      logic [WEIGHT_W-1:0] w;
      case (idx)
         4'd0:    w = 7'd0;
         4'd1:    w = 7'd4;
         4'd2:    w = 7'd9;
         4'd3:    w = 7'd13;
         4'd4:    w = 7'd17;
         4'd5:    w = 7'd21;
         4'd6:    w = 7'd26;
         4'd7:    w = 7'd30;
         4'd8:    w = 7'd34;
         4'd9:    w = 7'd38;
         4'd10:   w = 7'd43;
         4'd11:   w = 7'd47;
         4'd12:   w = 7'd51;
         4'd13:   w = 7'd55;
         4'd14:   w = 7'd60;
         4'd15:   w = 7'd64;
         default: w = 7'd0;
      endcase
      return w;
   endfunction

endpackage

[rtl/bc7m6_front.sv]
// Front end: checks the block mode and unpacks endpoints and indices into a
// block descriptor. Depends on bc7m6_pkg.
module bc7m6_front (
   input  logic [63:0]          block_low,
   input  logic [63:0]          block_high,
   output bc7m6_pkg::desc_type  desc
);

   logic p0;
   logic p1;

   assign p0 = block_low[63];
   assign p1 = block_high[0];

   // Mode check and endpoint unpack, channels interleaved low/high
   always_comb begin
      desc.mode_ok = (block_low[6:0] == bc7m6_pkg::MODE6_CODE);
      desc.ep0[0]  = {block_low[13:7],  p0};
      desc.ep1[0]  = {block_low[20:14], p1};
      desc.ep0[1]  = {block_low[27:21], p0};
      desc.ep1[1]  = {block_low[34:28], p1};
      desc.ep0[2]  = {block_low[41:35], p0};
      desc.ep1[2]  = {block_low[48:42], p1};
      desc.ep0[3]  = {block_low[55:49], p0};
      desc.ep1[3]  = {block_low[62:56], p1};
      // anchor index is 3 bits, the rest are 4 bits each
      desc.idx     = {block_high[63:4], 1'b0, block_high[3:1]};
   end

endmodule

[rtl/bc7m6_queue.sv]
// Two-entry descriptor queue between front and back.
// Depends on bc7m6_pkg.
module bc7m6_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bc7m6_pkg::desc_type  push_desc,
   input  logic                 pop,
   output bc7m6_pkg::desc_type  head_desc,
   output bc7m6_pkg::qstat_type stat
);

   bc7m6_pkg::desc_type entry_ff [bc7m6_pkg::QDEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       do_push;
   logic       do_pop;

   assign stat.empty = (count_ff == 2'd0);
   assign stat.full  = (count_ff == 2'(bc7m6_pkg::QDEPTH));
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head_desc  = entry_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

[rtl/bc7m6_back.sv]
// Back end: walks the sixteen texels of the head descriptor, blends the
// endpoints and holds each texel in an output register. Depends on bc7m6_pkg.
module bc7m6_back (
   input  logic                 clock,
   input  logic                 reset,
   input  bc7m6_pkg::desc_type  head_desc,
   input  bc7m6_pkg::qstat_type qstat,
   output logic                 q_pop,
   input  logic                 out_pop,
   output logic                 out_empty,
   output logic [3:0]           out_texel_index,
   output logic [7:0]           out_red,
   output logic [7:0]           out_green,
   output logic [7:0]           out_blue,
   output logic [7:0]           out_alpha,
   output logic                 out_mode_ok,
   output logic                 out_last_texel
);

   logic [3:0]       texel_ff, texel_in;
   logic             out_vld_ff, out_vld_in;
   logic             fire;
   logic [3:0]       cur_idx;
   logic [6:0]       cur_w;
   logic [3:0][7:0]  blend_val;
   logic [3:0][7:0]  chan_in;
   logic [3:0][7:0]  chan_ff;
   logic [3:0]       tidx_ff;
   logic             ok_ff;
   logic             last_ff;

   // Advance one texel when a descriptor waits and the output slot frees up
   assign fire  = !qstat.empty && (!out_vld_ff || out_pop);
   assign q_pop = fire && (texel_ff == bc7m6_pkg::LAST_TEXEL);

   assign cur_idx = head_desc.idx[texel_ff];
   assign cur_w   = bc7m6_pkg::weight(cur_idx);

   // Per-channel blend: (e0*64 + (e1-e0)*w + 32) >> 6
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         logic signed [8:0]  diff;
         logic signed [16:0] prod;
         logic signed [16:0] sum;
         diff = $signed({1'b0, head_desc.ep1[c]}) - $signed({1'b0, head_desc.ep0[c]});
         prod = 17'(diff) * 17'($signed({1'b0, cur_w}));
         sum  = $signed({3'b000, head_desc.ep0[c], 6'b00_0000}) + prod
              + $signed({10'd0, bc7m6_pkg::ROUND_BIAS});
         blend_val[c] = sum[13:6];
      end
   end

   // Choose blended texel or magenta fill
   always_comb begin
      if (head_desc.mode_ok) begin
         chan_in = blend_val;
      end else begin
         chan_in[0] = bc7m6_pkg::FILL_RED;
         chan_in[1] = bc7m6_pkg::FILL_GREEN;
         chan_in[2] = bc7m6_pkg::FILL_BLUE;
         chan_in[3] = bc7m6_pkg::FILL_ALPHA;
      end
   end

   // Texel counter and output valid
   always_comb begin
      texel_in   = fire ? texel_ff + 4'd1 : texel_ff;
      out_vld_in = out_vld_ff;
      if (fire) begin
         out_vld_in = 1'b1;
      end else if (out_pop) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         texel_ff   <= 4'd0;
         out_vld_ff <= 1'b0;
      end else begin
         texel_ff   <= texel_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (fire) begin
         chan_ff <= chan_in;
         tidx_ff <= texel_ff;
         ok_ff   <= head_desc.mode_ok;
         last_ff <= (texel_ff == bc7m6_pkg::LAST_TEXEL);
      end
   end

   assign out_empty       = !out_vld_ff;
   assign out_texel_index = tidx_ff;
   assign out_red         = chan_ff[0];
   assign out_green       = chan_ff[1];
   assign out_blue        = chan_ff[2];
   assign out_alpha       = chan_ff[3];
   assign out_mode_ok     = ok_ff;
   assign out_last_texel  = last_ff;

endmodule

[rtl/bc7_mode6_block_decoder.sv]
// BC7 mode 6 block decoder, top level. An accepted block is written into the
// queue; its sixteen texels then pass through the back end's output register.
// Throughput: one texel per cycle while a block waits and each texel is popped,
// set by the texel sequencer in the back end; a two-block queue decouples input.
// Reset is synchronous and active high; it empties the queue and output stage.
// Depends on bc7m6_pkg, bc7m6_front, bc7m6_queue, bc7m6_back.
module bc7_mode6_block_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [63:0] req_block_low,
   input  logic [63:0] req_block_high,
   output logic        empty,
   input  logic        pop,
   output logic [3:0]  rsp_texel_index,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic        rsp_mode_ok,
   output logic        rsp_last_texel
);

   bc7m6_pkg::desc_type  new_desc;
   bc7m6_pkg::desc_type  head_desc;
   bc7m6_pkg::qstat_type qstat;
   logic                 q_pop;

   assign full = qstat.full;

   // Classify and unpack
   bc7m6_front u_front (
      .block_low  (req_block_low),
      .block_high (req_block_high),
      .desc       (new_desc)
   );

   // Block queue
   bc7m6_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (new_desc),
      .pop       (q_pop),
      .head_desc (head_desc),
      .stat      (qstat)
   );

   // Texel generation
   bc7m6_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_desc       (head_desc),
      .qstat           (qstat),
      .q_pop           (q_pop),
      .out_pop         (pop),
      .out_empty       (empty),
      .out_texel_index (rsp_texel_index),
      .out_red         (rsp_red),
      .out_green       (rsp_green),
      .out_blue        (rsp_blue),
      .out_alpha       (rsp_alpha),
      .out_mode_ok     (rsp_mode_ok),
      .out_last_texel  (rsp_last_texel)
   );

`ifndef NO_ASSERTIONS
   // Texels of a block come out in order
   a_texel_order: assert property (@(posedge clock) disable iff (reset)
      pop && !empty && !rsp_last_texel |=>
         empty || rsp_texel_index == 4'($past(rsp_texel_index) + 4'd1))
      else $error("texel index skipped");

   // A new block starts at texel zero
   a_block_start: assert property (@(posedge clock) disable iff (reset)
      pop && !empty && rsp_last_texel |=> empty || rsp_texel_index == 4'd0)
      else $error("block did not restart at texel zero");

   // Last flag only on the final texel
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_last_texel == (rsp_texel_index == bc7m6_pkg::LAST_TEXEL))
      else $error("last_texel mismatch");

   // Non-mode-6 blocks give the magenta fill
   a_fill: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_mode_ok |->
         rsp_red == bc7m6_pkg::FILL_RED && rsp_green == bc7m6_pkg::FILL_GREEN &&
         rsp_blue == bc7m6_pkg::FILL_BLUE && rsp_alpha == bc7m6_pkg::FILL_ALPHA)
      else $error("bad fill color");
`endif

endmodule
